/* design/ols_pkg.sv */
// Package for the octant line stepper: widths, octant codes and the
// mirror functions between the original frame and the octant-zero frame.
// No dependencies.
package ols_pkg;

    // Coordinate width of one endpoint or pixel component
    localparam int COORD_BITS     = 12;
    // Frame coordinates and deltas need one bit more than the input
    localparam int FRAME_BITS     = COORD_BITS + 1;
    // Decision term spans about +/- 2 * 2^COORD_BITS
    localparam int ERR_BITS       = COORD_BITS + 4;
    // Stream payload widths, rounded up to whole bytes
    localparam int IN_DATA_BITS   = 4 * COORD_BITS;
    localparam int IN_TDATA_BITS  = ((IN_DATA_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS  = 2 * COORD_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_DATA_BITS + 7) / 8) * 8;

    // Action codes carried in tuser
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    typedef enum logic [2:0] {
        OCT_0 = 3'd0,
        OCT_1 = 3'd1,
        OCT_2 = 3'd2,
        OCT_3 = 3'd3,
        OCT_4 = 3'd4,
        OCT_5 = 3'd5,
        OCT_6 = 3'd6,
        OCT_7 = 3'd7
    } t_octant;

    typedef logic [FRAME_BITS-1:0] t_fcoord;

    typedef struct packed {
        t_fcoord a;
        t_fcoord b;
    } t_fpair;

    // Octant of a delta vector; equal endpoints fall into octant zero
    function automatic t_octant classify(input logic signed [FRAME_BITS-1:0] dx,
                                         input logic signed [FRAME_BITS-1:0] dy);
        logic signed [FRAME_BITS:0] sum;
        t_octant oc;
        sum = {dx[FRAME_BITS-1], dx} + {dy[FRAME_BITS-1], dy};
        if (dx == '0 && dy == '0) begin
            oc = OCT_0;
        end else if (dx > 0) begin
            if (dy > dx)         oc = OCT_1;
            else if (dy >= 0)    oc = OCT_0;
            else if (sum >= 0)   oc = OCT_7;
            else                 oc = OCT_6;
        end else if (dx == '0) begin
            oc = (dy > 0) ? OCT_1 : OCT_5;
        end else if (dy < 0) begin
            oc = (dy < dx) ? OCT_5 : OCT_4;
        end else begin
            oc = (sum <= 0) ? OCT_3 : OCT_2;
        end
        return oc;
    endfunction

    // Map a point into the octant-zero frame: a = u, b = v
    function automatic t_fpair into_zero(input t_octant oc, input t_fcoord x,
                                         input t_fcoord y);
        t_fpair p;
        case (oc)
            OCT_1:   begin p.a = y;      p.b = x;      end
            OCT_2:   begin p.a = y;      p.b = -x;     end
            OCT_3:   begin p.a = -x;     p.b = y;      end
            OCT_4:   begin p.a = -x;     p.b = -y;     end
            OCT_5:   begin p.a = -y;     p.b = -x;     end
            OCT_6:   begin p.a = -y;     p.b = x;      end
            OCT_7:   begin p.a = x;      p.b = -y;     end
            default: begin p.a = x;      p.b = y;      end
        endcase
        return p;
    endfunction

    // Map a frame point back to the original octant: a = x, b = y
    function automatic t_fpair out_of_zero(input t_octant oc, input t_fcoord u,
                                           input t_fcoord v);
        t_fpair p;
        case (oc)
            OCT_1:   begin p.a = v;      p.b = u;      end
            OCT_2:   begin p.a = -v;     p.b = u;      end
            OCT_3:   begin p.a = -u;     p.b = v;      end
            OCT_4:   begin p.a = -u;     p.b = -v;     end
            OCT_5:   begin p.a = -v;     p.b = -u;     end
            OCT_6:   begin p.a = v;      p.b = -u;     end
            OCT_7:   begin p.a = u;      p.b = -v;     end
            default: begin p.a = u;      p.b = v;      end
        endcase
        return p;
    endfunction

endpackage

/* design/octant_line_stepper_core.sv */
// Octant line stepper top level: Bresenham line generator for all eight octants.
// Depends on ols_pkg (widths, octant codes, mirror functions).
//
// Channel | Dir | Handshake              | Payload
// --------+-----+------------------------+------------------------------------------
// s_axis  | in  | tvalid / tready        | tuser: action; tdata: start_x, start_y,
//         |     |                        |   end_x, end_y (12 bits each, low first)
// m_axis  | out | tvalid / tready        | tdata: pixel_x, pixel_y; tlast: last
//
// One item per cycle while s_axis_tready is high: a load or a step is handled in
// the cycle it transfers, by one short mux/add path from the line registers into
// the output register, or the skid register when m_axis stalls, then to m_axis.
// Reset (i_rst_n low, synchronous) drops any loaded line and empties the output.
// A stalled m_axis fills a one-entry skid register; s_axis_tready falls only
// while that skid entry is occupied.
module octant_line_stepper_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [11:0] start_x, [23:12] start_y, [35:24] end_x, [47:36] end_y
    input  logic [ols_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
    // [0] action: 0 load, 1 step
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [11:0] pixel_x, [23:12] pixel_y
    output logic [ols_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
    output logic                                m_axis_tlast
);

    localparam int CB = ols_pkg::COORD_BITS;
    localparam int FB = ols_pkg::FRAME_BITS;
    localparam int EB = ols_pkg::ERR_BITS;

    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic          last;
    } t_pixel;

    // Line state
    logic                       r_active, n_active;
    ols_pkg::t_octant           r_octant, n_octant;
    ols_pkg::t_fcoord           r_start_u, n_start_u;
    ols_pkg::t_fcoord           r_frame_v, n_frame_v;
    ols_pkg::t_fcoord           r_frame_dx, n_frame_dx;
    ols_pkg::t_fcoord           r_frame_dy, n_frame_dy;
    logic signed [EB-1:0]       r_err, n_err;
    logic [FB-1:0]              r_step, n_step;

    // Output and skid registers
    logic                       r_out_valid, n_out_valid;
    t_pixel                     r_out, n_out;
    logic                       r_skid_valid, n_skid_valid;
    t_pixel                     r_skid, n_skid;

    logic                       in_xfer;
    logic                       out_xfer;
    logic                       res_valid;
    t_pixel                     res;

    logic signed [FB-1:0]       ax, ay, bx, by, dx, dy;
    ols_pkg::t_octant           ld_oct;
    ols_pkg::t_fpair            ld_start, ld_delta, px;
    logic signed [EB-1:0]       fdx_ext, fdy_ext;

    assign s_axis_tready = !r_skid_valid;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = r_out_valid && m_axis_tready;

    // Load path: deltas, octant, mirrored start and deltas
    always_comb begin
        ax       = FB'($signed(s_axis_tdata[CB-1:0]));
        ay       = FB'($signed(s_axis_tdata[2*CB-1:CB]));
        bx       = FB'($signed(s_axis_tdata[3*CB-1:2*CB]));
        by       = FB'($signed(s_axis_tdata[4*CB-1:3*CB]));
        dx       = bx - ax;
        dy       = by - ay;
        ld_oct   = ols_pkg::classify(dx, dy);
        ld_start = ols_pkg::into_zero(ld_oct, ax, ay);
        ld_delta = ols_pkg::into_zero(ld_oct, dx, dy);
    end

    // Step path: current pixel mirrored back, next decision term
    always_comb begin
        px        = ols_pkg::out_of_zero(r_octant, r_start_u + r_step, r_frame_v);
        res.x     = px.a[CB-1:0];
        res.y     = px.b[CB-1:0];
        res.last  = (r_step == r_frame_dx);
        fdx_ext   = EB'($signed(r_frame_dx));
        fdy_ext   = EB'($signed(r_frame_dy));
        res_valid = in_xfer && (s_axis_tuser == ols_pkg::ACT_STEP) && r_active;
    end

    // Next line state
    always_comb begin
        n_active   = r_active;
        n_octant   = r_octant;
        n_start_u  = r_start_u;
        n_frame_v  = r_frame_v;
        n_frame_dx = r_frame_dx;
        n_frame_dy = r_frame_dy;
        n_err      = r_err;
        n_step     = r_step;
        if (in_xfer && s_axis_tuser == ols_pkg::ACT_LOAD) begin
            n_active   = 1'b1;
            n_octant   = ld_oct;
            n_start_u  = ld_start.a;
            n_frame_v  = ld_start.b;
            n_frame_dx = ld_delta.a;
            n_frame_dy = ld_delta.b;
            n_err      = (EB'($signed(ld_delta.b)) <<< 1) - EB'($signed(ld_delta.a));
            n_step     = '0;
        end else if (res_valid) begin
            if (r_err > 0) begin
                n_frame_v = r_frame_v + FB'(1);
                n_err     = r_err + (fdy_ext <<< 1) - (fdx_ext <<< 1);
            end else begin
                n_err     = r_err + (fdy_ext <<< 1);
            end
            n_step = r_step + FB'(1);
            if (res.last) begin
                n_active = 1'b0;
            end
        end
    end

    // Output register with one skid entry
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || out_xfer) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid  = res_valid;
                n_out        = res;
            end
        end else if (res_valid) begin
            n_skid_valid = 1'b1;
            n_skid       = res;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_octant     <= ols_pkg::OCT_0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_active     <= n_active;
            r_octant     <= n_octant;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_start_u  <= n_start_u;
        r_frame_v  <= n_frame_v;
        r_frame_dx <= n_frame_dx;
        r_frame_dy <= n_frame_dy;
        r_err      <= n_err;
        r_step     <= n_step;
        r_out      <= n_out;
        r_skid     <= n_skid;
    end

    // Output packing
    always_comb begin
        m_axis_tvalid               = r_out_valid;
        m_axis_tlast                = r_out.last;
        m_axis_tdata                = '0;
        m_axis_tdata[CB-1:0]        = r_out.x;
        m_axis_tdata[2*CB-1:CB]     = r_out.y;
    end

endmodule

/* sim/tb_top.sv */
// Testbench for octant_line_stepper_core: directed line table, then random loads and steps
// checked against a behavioral Bresenham predictor, with random stalls on both streams.
// Depends on ols_pkg and octant_line_stepper_core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB         = ols_pkg::COORD_BITS;
    localparam int IN_W       = ols_pkg::IN_TDATA_BITS;
    localparam int OUT_W      = ols_pkg::OUT_TDATA_BITS;
    localparam int RUN_ITEMS  = 24 + 900;
    localparam int QUIET_TAIL = 120;

    typedef struct packed {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic                 last;
    } t_pixel_exp;

    typedef struct {
        logic       act;
        int         sx;
        int         sy;
        int         ex;
        int         ey;
        bit         chk;
        t_pixel_exp want;
    } t_line_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;
    logic             s_axis_tuser;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             m_axis_tlast;

    // Predictor copy of the line registers
    bit               ln_active;
    ols_pkg::t_octant ln_oct;
    int               ln_u0;
    int               ln_v;
    int               ln_du;
    int               ln_dv;
    int               ln_err;
    int               ln_idx;
    int               ln_len;

    t_pixel_exp pixel_q[$];
    int         err_count;
    int         sent_count;
    bit         quiet;
    t_line_row  dir_rows [0:23];

    octant_line_stepper_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Octant from the endpoint deltas; a zero-length line counts as octant zero
    function automatic ols_pkg::t_octant line_octant(input int dx, input int dy);
        if (dx == 0 && dy == 0) return ols_pkg::OCT_0;
        if (dx > 0) begin
            if (dy > dx) return ols_pkg::OCT_1;
            if (dy >= 0) return ols_pkg::OCT_0;
            if (-dy <= dx) return ols_pkg::OCT_7;
            return ols_pkg::OCT_6;
        end
        if (dx == 0) return (dy > 0) ? ols_pkg::OCT_1 : ols_pkg::OCT_5;
        if (dy < 0) return (dy < dx) ? ols_pkg::OCT_5 : ols_pkg::OCT_4;
        return (dy <= -dx) ? ols_pkg::OCT_3 : ols_pkg::OCT_2;
    endfunction

    // Mirror a point into the octant-zero frame
    task automatic to_frame(input ols_pkg::t_octant oc, input int x, input int y,
                            output int u, output int v);
        case (oc)
            ols_pkg::OCT_1: begin u = y;  v = x;  end
            ols_pkg::OCT_2: begin u = y;  v = -x; end
            ols_pkg::OCT_3: begin u = -x; v = y;  end
            ols_pkg::OCT_4: begin u = -x; v = -y; end
            ols_pkg::OCT_5: begin u = -y; v = -x; end
            ols_pkg::OCT_6: begin u = -y; v = x;  end
            ols_pkg::OCT_7: begin u = x;  v = -y; end
            default:        begin u = x;  v = y;  end
        endcase
    endtask

    // Mirror a frame point back into the line's own octant
    task automatic from_frame(input ols_pkg::t_octant oc, input int u, input int v,
                              output int x, output int y);
        case (oc)
            ols_pkg::OCT_1: begin x = v;  y = u;  end
            ols_pkg::OCT_2: begin x = -v; y = u;  end
            ols_pkg::OCT_3: begin x = -u; y = v;  end
            ols_pkg::OCT_4: begin x = -u; y = -v; end
            ols_pkg::OCT_5: begin x = -v; y = -u; end
            ols_pkg::OCT_6: begin x = v;  y = -u; end
            ols_pkg::OCT_7: begin x = u;  y = -v; end
            default:        begin x = u;  y = v;  end
        endcase
    endtask

    // Advance the line state by one transfer; returns whether a pixel comes out
    task automatic trace_line(input logic act, input logic [IN_W-1:0] data,
                              output bit hit, output t_pixel_exp px);
        int ax, ay, bx, by;
        int au, av, bu, bv;
        int x, y;
        hit = 1'b0;
        px  = '0;
        if (act == ols_pkg::ACT_LOAD) begin
            ax = int'($signed(data[CB-1:0]));
            ay = int'($signed(data[2*CB-1:CB]));
            bx = int'($signed(data[3*CB-1:2*CB]));
            by = int'($signed(data[4*CB-1:3*CB]));
            ln_oct = line_octant(bx - ax, by - ay);
            to_frame(ln_oct, ax, ay, au, av);
            to_frame(ln_oct, bx, by, bu, bv);
            ln_u0     = au;
            ln_v      = av;
            ln_du     = bu - au;
            ln_dv     = bv - av;
            ln_err    = 2 * ln_dv - ln_du;
            ln_idx    = 0;
            ln_len    = ln_du + 1;
            ln_active = 1'b1;
        end else if (ln_active) begin
            from_frame(ln_oct, ln_u0 + ln_idx, ln_v, x, y);
            hit     = 1'b1;
            px.x    = x[CB-1:0];
            px.y    = y[CB-1:0];
            px.last = (ln_idx + 1 == ln_len);
            if (ln_err > 0) begin
                ln_v   += 1;
                ln_err -= 2 * ln_du;
            end
            ln_err += 2 * ln_dv;
            ln_idx += 1;
            if (px.last) ln_active = 1'b0;
        end
    endtask

    function automatic logic [IN_W-1:0] pack_line(input int sx, input int sy,
                                                  input int ex, input int ey);
        logic [IN_W-1:0] d;
        d = '0;
        d[CB-1:0]      = sx[CB-1:0];
        d[2*CB-1:CB]   = sy[CB-1:0];
        d[3*CB-1:2*CB] = ex[CB-1:0];
        d[4*CB-1:3*CB] = ey[CB-1:0];
        return d;
    endfunction

    function automatic int clamp_coord(input int c);
        if (c > 2047) return 2047;
        if (c < -2048) return -2048;
        return c;
    endfunction

    function automatic int abs_int(input int a);
        return (a < 0) ? -a : a;
    endfunction

    // One transfer on s_axis; entered and left at a falling edge
    task automatic send_item(input logic act, input logic [IN_W-1:0] data,
                             input bit chk, input t_pixel_exp typed);
        bit         hit;
        t_pixel_exp px;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        trace_line(act, data, hit, px);
        if (hit) pixel_q.insert(pixel_q.size(), chk ? typed : px);
        else if (chk) flag_error("directed row expects a pixel but none is predicted");
        sent_count++;
        @(negedge i_clk);
    endtask

    function automatic logic [IN_W-1:0] rand_tdata();
        return IN_W'({$urandom(), $urandom()});
    endfunction

    // Receiver stalls in bursts, none in the tail of the run
    initial begin
        m_axis_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Pixel check against the oldest expectation
    always @(posedge i_clk) begin : pixel_check
        t_pixel_exp want;
        logic signed [CB-1:0] gx, gy;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            gx = m_axis_tdata[CB-1:0];
            gy = m_axis_tdata[2*CB-1:CB];
            if (pixel_q.size() == 0) begin
                flag_error($sformatf("unexpected pixel (%0d,%0d) last=%0b",
                                     gx, gy, m_axis_tlast));
            end else begin
                want = pixel_q.pop_front();
                if (gx !== want.x)
                    flag_error($sformatf("pixel_x got %0d want %0d", gx, want.x));
                if (gy !== want.y)
                    flag_error($sformatf("pixel_y got %0d want %0d", gy, want.y));
                if (m_axis_tlast !== want.last)
                    flag_error($sformatf("last got %0b want %0b at (%0d,%0d)",
                                         m_axis_tlast, want.last, want.x, want.y));
            end
        end
    end

    initial begin
        int sx, sy, ex, ey, kind, span, n;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = ols_pkg::ACT_LOAD;
        s_axis_tdata  = '0;
        err_count     = 0;
        sent_count    = 0;
        quiet         = 1'b0;
        ln_active     = 1'b0;
        ln_oct        = ols_pkg::OCT_0;
        ln_u0 = 0; ln_v = 0; ln_du = 0; ln_dv = 0; ln_err = 0; ln_idx = 0; ln_len = 0;

        // Directed lines: idle steps, zero-length lines at both extremes, full-span
        // diagonal (octant 7) cut short by a load, and short lines in octants 0 to 6
        dir_rows = '{
            '{ols_pkg::ACT_STEP,     0,     0,     0,     0, 1'b0, '0},
            '{ols_pkg::ACT_LOAD, -2048, -2048, -2048, -2048, 1'b0, '0},
            '{ols_pkg::ACT_STEP,     0,     0,     0,     0, 1'b1,
              '{-12'sd2048, -12'sd2048, 1'b1}},
            '{ols_pkg::ACT_STEP,     0,     0,     0,     0, 1'b0, '0},
            '{ols_pkg::ACT_LOAD,  2047,  2047,  2047,  2047, 1'b0, '0},
            '{ols_pkg::ACT_STEP,     0,     0,     0,     0, 1'b1,
              '{12'sd2047, 12'sd2047, 1'b1}},
            '{ols_pkg::ACT_LOAD, -2048,  2047,  2047, -2048, 1'b0, '0},
            '{ols_pkg::ACT_STEP,     0,     0,     0,     0, 1'b1,
              '{-12'sd2048, 12'sd2047, 1'b0}},
            '{ols_pkg::ACT_LOAD,     0,     0,     2,     1, 1'b0, '0},
            '{ols_pkg::ACT_STEP,     0,     0,     0,     0, 1'b1, '{12'sd0, 12'sd0, 1'b0}},
            '{ols_pkg::ACT_STEP,     0,     0,     0,     0, 1'b0, '0},
            '{ols_pkg::ACT_STEP,     0,     0,     0,     0, 1'b0, '0},
            '{ols_pkg::ACT_LOAD,     5,    -3,     6,     0, 1'b0, '0},
            '{ols_pkg::ACT_STEP,     0,     0,     0,     0, 1'b1, '{12'sd5, -12'sd3, 1'b0}},
            '{ols_pkg::ACT_LOAD,    10,    10,     9,    12, 1'b0, '0},
            '{ols_pkg::ACT_STEP,     0,     0,     0,     0, 1'b1,
              '{12'sd10, 12'sd10, 1'b0}},
            '{ols_pkg::ACT_LOAD,     0,     0,    -3,     1, 1'b0, '0},
            '{ols_pkg::ACT_STEP,     0,     0,     0,     0, 1'b1, '{12'sd0, 12'sd0, 1'b0}},
            '{ols_pkg::ACT_LOAD,     0,     0,    -3,    -2, 1'b0, '0},
            '{ols_pkg::ACT_STEP,     0,     0,     0,     0, 1'b0, '0},
            '{ols_pkg::ACT_LOAD,     0,     0,     0,    -4, 1'b0, '0},
            '{ols_pkg::ACT_STEP,     0,     0,     0,     0, 1'b0, '0},
            '{ols_pkg::ACT_LOAD,     0,     0,     2,    -5, 1'b0, '0},
            '{ols_pkg::ACT_STEP,     0,     0,     0,     0, 1'b0, '0}
        };

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].act,
                      pack_line(dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].ex, dir_rows[i].ey),
                      dir_rows[i].chk, dir_rows[i].want);

        // Random lines: mostly short complete lines, some cut short, some overrun,
        // a few full-range lines stepped briefly, and stray steps as noise
        while (sent_count < RUN_ITEMS) begin
            quiet = (sent_count >= RUN_ITEMS - QUIET_TAIL);
            kind  = $urandom_range(0, 9);
            if (kind == 0) begin
                repeat ($urandom_range(1, 3))
                    send_item(ols_pkg::ACT_STEP, rand_tdata(), 1'b0, '0);
            end else begin
                sx = int'($urandom_range(0, 4095)) - 2048;
                sy = int'($urandom_range(0, 4095)) - 2048;
                if (kind == 1) begin
                    ex = int'($urandom_range(0, 4095)) - 2048;
                    ey = int'($urandom_range(0, 4095)) - 2048;
                end else if (kind == 2) begin
                    ex = sx;
                    ey = sy;
                end else begin
                    ex = clamp_coord(sx + int'($urandom_range(0, 40)) - 20);
                    ey = clamp_coord(sy + int'($urandom_range(0, 40)) - 20);
                end
                span = ((abs_int(ex - sx) > abs_int(ey - sy)) ?
                        abs_int(ex - sx) : abs_int(ey - sy)) + 1;
                if (kind == 1) n = $urandom_range(1, 24);
                else if ($urandom_range(0, 7) == 0) n = $urandom_range(0, span);
                else n = span + $urandom_range(0, 2);
                send_item(ols_pkg::ACT_LOAD, pack_line(sx, sy, ex, ey), 1'b0, '0);
                repeat (n) send_item(ols_pkg::ACT_STEP, rand_tdata(), 1'b0, '0);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
